// File: src/psu_pkg.sv
`default_nettype none
package psu_pkg;

    localparam int BYTE_W          = 8;
    localparam int BPP_W           = 4;
    localparam int ROW_BYTES_W     = 14;
    localparam int CFG_DATA_W      = 14;
    localparam int CFG_INDEX_W     = 1;

    localparam int MAX_ROW_BYTES_DEF = 8192;
    localparam int MAX_BPP_DEF       = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_BPP       = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES = 1'd1;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    typedef struct packed {
        filter_t           filter;
        logic [BYTE_W-1:0] left;
        logic [BYTE_W-1:0] up;
        logic [BYTE_W-1:0] upleft;
    } pred_in_t;

endpackage
`default_nettype wire

// File: src/png_scanline_unfilter_unit.sv
`default_nettype none
// Channel  | Dir | Beat contents (lsb first)              | Handshake
// s_       | in  | tdata: in_byte; tuser: start_image      | s_tvalid/s_tready
// m_       | out | tdata: out_byte; tlast: row_end;       | m_tvalid/m_tready
//          |     | tuser: bad_filter                      |
// cfg_     | in  | index 0 bytes_per_pixel, 1 row_bytes   | cfg_wr_en
//
// One byte per cycle sustained while m_ is ready; a data byte passes the
// input register, then the result register, on its way to m_. Filter type
// bytes yield no output beat. The line buffer read is prefetched ahead
// through its registered port, so rows of any length run at full rate.
// aresetn is synchronous; the line buffer contents are not cleared.
// m_tready low stalls data bytes in the input register; s_tready drops only
// when that register is full and cannot drain.
module png_scanline_unfilter_unit #(
    parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_BPP       = psu_pkg::MAX_BPP_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [7:0]                       s_tdata,   // in_byte
    input  wire  [0:0]                       s_tuser,   // start_image
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [7:0]                       m_tdata,   // out_byte
    output logic                             m_tlast,
    output logic [0:0]                       m_tuser,   // bad_filter
    input  wire                              cfg_wr_en,
    input  wire  [psu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [psu_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int CW = AW + 1;
    localparam int RW = (CW > psu_pkg::ROW_BYTES_W) ? CW : psu_pkg::ROW_BYTES_W;
    localparam int SW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
    localparam logic [RW-1:0] MAX_RB = RW'(MAX_ROW_BYTES);

    logic [psu_pkg::BPP_W-1:0]       bpp_reg;
    logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_reg;

    logic                        in_valid_reg;
    logic [psu_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        in_start_reg;

    logic [AW-1:0]               column_reg;
    logic [AW-1:0]               column_next;
    psu_pkg::filter_t            row_filter_reg;
    logic                        expect_type_reg;
    logic                        first_row_reg;
    logic                        row_bad_reg;
    logic [SW-1:0]               resid_reg [MAX_BPP];
    logic [psu_pkg::BYTE_W-1:0]  left_hist_reg [MAX_BPP];
    logic [psu_pkg::BYTE_W-1:0]  upleft_hist_reg [MAX_BPP];

    logic                        out_valid_reg;
    logic [psu_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                        out_last_reg;
    logic                        out_bad_reg;

    logic                        is_type;
    logic                        out_free;
    logic                        fire;
    logic                        type_fire;
    logic                        data_fire;
    logic [SW-1:0]               bpp_idx;
    logic [SW-1:0]               slot;
    logic [RW-1:0]               rb_eff;
    logic [CW-1:0]               col_inc;
    logic                        last;
    logic [psu_pkg::BYTE_W-1:0]  prior_byte;
    logic [psu_pkg::BYTE_W-1:0]  up_byte;
    logic [psu_pkg::BYTE_W-1:0]  pred;
    logic [psu_pkg::BYTE_W-1:0]  res;
    psu_pkg::pred_in_t           pred_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg       <= psu_pkg::BPP_W'(1);
            row_bytes_reg <= psu_pkg::ROW_BYTES_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                psu_pkg::CFG_BPP:       bpp_reg <= cfg_wdata[psu_pkg::BPP_W-1:0];
                psu_pkg::CFG_ROW_BYTES: row_bytes_reg <= cfg_wdata;
                default:                bpp_reg <= bpp_reg;
            endcase
        end
    end

    assign is_type   = in_start_reg || expect_type_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && (is_type || out_free);
    assign type_fire = fire && is_type;
    assign data_fire = fire && !is_type;
    assign s_tready  = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    always_comb begin
        if (bpp_reg == '0) begin
            bpp_idx = '0;
        end else if (bpp_reg > psu_pkg::BPP_W'(MAX_BPP)) begin
            bpp_idx = SW'(MAX_BPP - 1);
        end else begin
            bpp_idx = SW'(bpp_reg - psu_pkg::BPP_W'(1));
        end
        slot = resid_reg[bpp_idx];
    end

    always_comb begin
        rb_eff = RW'(row_bytes_reg);
        if (rb_eff == '0) begin
            rb_eff = RW'(1);
        end else if (rb_eff > MAX_RB) begin
            rb_eff = MAX_RB;
        end
        col_inc = {1'b0, column_reg} + CW'(1);
        last    = RW'(col_inc) >= rb_eff;
    end

    always_comb begin
        if (type_fire) begin
            column_next = '0;
        end else if (data_fire) begin
            column_next = last ? '0 : col_inc[AW-1:0];
        end else begin
            column_next = column_reg;
        end
    end

    psu_line_buf #(
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (data_fire),
        .wr_addr (column_reg),
        .wr_data (res),
        .rd_addr (column_next),
        .rd_data (prior_byte)
    );

    assign up_byte        = first_row_reg ? '0 : prior_byte;
    assign pred_in.filter = row_filter_reg;
    assign pred_in.left   = left_hist_reg[slot];
    assign pred_in.up     = up_byte;
    assign pred_in.upleft = upleft_hist_reg[slot];

    psu_predictor u_predictor (
        .pred_in (pred_in),
        .pred    (pred)
    );

    assign res = in_byte_reg + pred;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg      <= '0;
            row_filter_reg  <= psu_pkg::FILT_NONE;
            expect_type_reg <= 1'b1;
            first_row_reg   <= 1'b1;
            row_bad_reg     <= 1'b0;
            for (int k = 0; k < MAX_BPP; k++) begin
                resid_reg[k]       <= '0;
                left_hist_reg[k]   <= '0;
                upleft_hist_reg[k] <= '0;
            end
        end else begin
            column_reg <= column_next;
            if (type_fire) begin
                expect_type_reg <= 1'b0;
                if (in_start_reg) begin
                    first_row_reg <= 1'b1;
                end
                if (in_byte_reg > psu_pkg::BYTE_W'(psu_pkg::FILT_PAETH)) begin
                    row_filter_reg <= psu_pkg::FILT_NONE;
                    row_bad_reg    <= 1'b1;
                end else begin
                    row_filter_reg <= psu_pkg::filter_t'(in_byte_reg[2:0]);
                    row_bad_reg    <= 1'b0;
                end
                for (int k = 0; k < MAX_BPP; k++) begin
                    resid_reg[k]       <= '0;
                    left_hist_reg[k]   <= '0;
                    upleft_hist_reg[k] <= '0;
                end
            end else if (data_fire) begin
                left_hist_reg[slot]   <= res;
                upleft_hist_reg[slot] <= up_byte;
                for (int k = 0; k < MAX_BPP; k++) begin
                    resid_reg[k] <= (resid_reg[k] == SW'(k)) ? '0 : resid_reg[k] + SW'(1);
                end
                if (last) begin
                    expect_type_reg <= 1'b1;
                    first_row_reg   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (data_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_fire) begin
            out_byte_reg <= res;
            out_last_reg <= last;
            out_bad_reg  <= row_bad_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_bad_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        data_fire |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while held");

    a_type_no_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (type_fire && out_free) |=> !out_valid_reg)
        else $error("type byte produced an output beat");

    a_row_end_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        (data_fire && last) |=> (expect_type_reg && column_reg == '0))
        else $error("row end did not rearm type byte");

    a_column_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        RW'(column_reg) < MAX_RB)
        else $error("column beyond line buffer");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        slot <= bpp_idx)
        else $error("history slot beyond pixel width");

endmodule
`default_nettype wire

// File: src/psu_predictor.sv
`default_nettype none
module psu_predictor (
    input  var psu_pkg::pred_in_t        pred_in,
    output logic [psu_pkg::BYTE_W-1:0]   pred
);

    logic [psu_pkg::BYTE_W-1:0] pa;
    logic [psu_pkg::BYTE_W-1:0] pb;
    logic [psu_pkg::BYTE_W:0]   pc;
    logic [psu_pkg::BYTE_W:0]   sum_ab;
    logic [psu_pkg::BYTE_W:0]   two_c;
    logic [psu_pkg::BYTE_W-1:0] paeth;

    always_comb begin
        sum_ab = {1'b0, pred_in.left} + {1'b0, pred_in.up};
        two_c  = {pred_in.upleft, 1'b0};
        pa = (pred_in.up >= pred_in.upleft) ? pred_in.up - pred_in.upleft
                                            : pred_in.upleft - pred_in.up;
        pb = (pred_in.left >= pred_in.upleft) ? pred_in.left - pred_in.upleft
                                              : pred_in.upleft - pred_in.left;
        pc = (sum_ab >= two_c) ? sum_ab - two_c : two_c - sum_ab;
        if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
            paeth = pred_in.left;
        end else if ({1'b0, pb} <= pc) begin
            paeth = pred_in.up;
        end else begin
            paeth = pred_in.upleft;
        end
    end

    always_comb begin
        case (pred_in.filter)
            psu_pkg::FILT_SUB:   pred = pred_in.left;
            psu_pkg::FILT_UP:    pred = pred_in.up;
            psu_pkg::FILT_AVG:   pred = sum_ab[psu_pkg::BYTE_W:1];
            psu_pkg::FILT_PAETH: pred = paeth;
            default:             pred = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: src/psu_line_buf.sv
`default_nettype none
module psu_line_buf #(
    parameter  int DEPTH = psu_pkg::MAX_ROW_BYTES_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                         aclk,
    input  wire                         wr_en,
    input  wire  [AW-1:0]               wr_addr,
    input  wire  [psu_pkg::BYTE_W-1:0]  wr_data,
    input  wire  [AW-1:0]               rd_addr,
    output logic [psu_pkg::BYTE_W-1:0]  rd_data
);

    logic [psu_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [psu_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // forward a same-cycle write to the read port
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: tb/sv/png_recon_checker.sv
`timescale 1ns / 100ps
module png_recon_checker
    import psu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
    parameter int MAX_BPP       = MAX_BPP_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    input  wire                    s_tready,
    input  wire  [7:0]             s_tdata,   // in_byte
    input  wire  [0:0]             s_tuser,   // start_image
    input  wire                    m_tvalid,
    input  wire                    m_tready,
    input  wire  [7:0]             m_tdata,   // out_byte
    input  wire                    m_tlast,
    input  wire  [0:0]             m_tuser,   // bad_filter
    input  wire                    cfg_wr_en,
    input  wire  [CFG_INDEX_W-1:0] cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     fail_count,
    output int                     pending_count,
    output int                     result_count
);

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
        logic       bad;
    } recon_t;

    recon_t                 recon_q[$];
    logic [7:0]             line_buf    [MAX_ROW_BYTES];
    logic [7:0]             left_hist   [MAX_BPP];
    logic [7:0]             upleft_hist [MAX_BPP];
    int unsigned            col;
    filter_t                row_filt;
    bit                     want_type;
    bit                     first_row;
    bit                     bad_row;
    logic [BPP_W-1:0]       cfg_bpp;
    logic [ROW_BYTES_W-1:0] cfg_rb;
    int                     errs;
    int                     seen;

    function automatic int paeth_select(input int a, input int b, input int c);
        int pa;
        int pb;
        int pc;
        pa = (b > c) ? b - c : c - b;
        pb = (a > c) ? a - c : c - a;
        pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
        if (pa <= pb && pa <= pc) begin
            return a;
        end
        if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

    task automatic clear_history();
        int i;
        for (i = 0; i < MAX_BPP; i++) begin
            left_hist[i]   = 8'd0;
            upleft_hist[i] = 8'd0;
        end
    endtask

    task automatic reconstruct_byte(input logic [7:0] in_b, input logic img_start);
        int unsigned eff_bpp;
        int unsigned eff_rb;
        int unsigned slot;
        int          a;
        int          b;
        int          c;
        int          pred;
        logic [7:0]  pix;
        bit          last;
        if (img_start) begin
            first_row = 1'b1;
            want_type = 1'b1;
        end
        if (want_type) begin
            if (in_b > 8'd4) begin
                row_filt = FILT_NONE;
                bad_row  = 1'b1;
            end else begin
                row_filt = filter_t'(in_b[2:0]);
                bad_row  = 1'b0;
            end
            col = 0;
            clear_history();
            want_type = 1'b0;
        end else begin
            eff_bpp = (cfg_bpp == 0) ? 1 : ((cfg_bpp > MAX_BPP) ? MAX_BPP : cfg_bpp);
            eff_rb  = (cfg_rb == 0) ? 1 : ((cfg_rb > MAX_ROW_BYTES) ? MAX_ROW_BYTES : cfg_rb);
            if (col >= MAX_ROW_BYTES) begin
                col = MAX_ROW_BYTES - 1;
            end
            slot = col % eff_bpp;
            a = int'(left_hist[slot]);
            b = first_row ? 0 : int'(line_buf[col]);
            c = int'(upleft_hist[slot]);
            case (row_filt)
                FILT_SUB:   pred = a;
                FILT_UP:    pred = b;
                FILT_AVG:   pred = (a + b) / 2;
                FILT_PAETH: pred = paeth_select(a, b, c);
                default:    pred = 0;
            endcase
            pix = in_b + pred[7:0];
            left_hist[slot]   = pix;
            upleft_hist[slot] = b[7:0];
            line_buf[col]     = pix;
            col++;
            last = (col >= eff_rb);
            recon_q.push_back({pix, last, bad_row});
            if (last) begin
                col       = 0;
                want_type = 1'b1;
                first_row = 1'b0;
            end
        end
    endtask

    task automatic check_result();
        recon_t got;
        recon_t exp;
        got = {m_tdata, m_tlast, m_tuser[0]};
        seen++;
        if (recon_q.size() == 0) begin
            errs++;
            if (errs <= 10) begin
                $display("unexpected beat: byte %02h last %b bad %b",
                         got.pixel, got.row_end, got.bad);
            end
        end else begin
            exp = recon_q.pop_front();
            if (got !== exp) begin
                errs++;
                if (errs <= 10) begin
                    $display({"mismatch at beat %0d: expected byte %02h last %b bad %b,",
                              " got byte %02h last %b bad %b"},
                             seen, exp.pixel, exp.row_end, exp.bad,
                             got.pixel, got.row_end, got.bad);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            recon_q.delete();
            clear_history();
            col       = 0;
            row_filt  = FILT_NONE;
            want_type = 1'b1;
            first_row = 1'b1;
            bad_row   = 1'b0;
            cfg_bpp   = BPP_W'(1);
            cfg_rb    = ROW_BYTES_W'(1);
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (s_tvalid && s_tready) begin
                reconstruct_byte(s_tdata, s_tuser[0]);
            end
            if (cfg_wr_en) begin
                if (cfg_index == CFG_BPP) begin
                    cfg_bpp = cfg_wdata[BPP_W-1:0];
                end else if (cfg_index == CFG_ROW_BYTES) begin
                    cfg_rb = cfg_wdata[ROW_BYTES_W-1:0];
                end
            end
        end
        fail_count    <= errs;
        pending_count <= recon_q.size();
        result_count  <= seen;
    end

endmodule

// File: tb/sv/tb_png_scanline_unfilter_unit.sv
`timescale 1ns / 100ps
module tb_png_scanline_unfilter_unit;
    import psu_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'd0;
    logic [0:0]             s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   m_tlast;
    logic [0:0]             m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_BPP;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending_count;
    int result_count;
    int cycles     = 0;
    int beats_in   = 0;
    int n_settings = 0;
    int hold_reqs  = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    png_scanline_unfilter_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    png_recon_checker i_recon_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycles, pending_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_type(input bit allow_bad);
        if (allow_bad && $urandom_range(0, 99) < 15) begin
            return 8'($urandom_range(5, 255));
        end
        return 8'($urandom_range(FILT_NONE, FILT_PAETH));
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall_left;
        int hold_done;
        stall_left = 0;
        hold_done  = 0;
        forever begin
            @(negedge aclk);
            if (hold_reqs != hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done++;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (rx_idle_en && $urandom_range(0, 99) < 15) begin
                m_tready   <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic st);
        int g;
        if (tx_idle_en && $urandom_range(0, 99) < 20) begin
            g = pick_gap();
            repeat (g) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_in++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic cfg_end();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic run_phase(input int bpp, input int rb, input int n_items,
                             input bit tx_idle, input bit rx_idle,
                             input bit noisy, input bit hold);
        int         rb_eff;
        int         left;
        int         i;
        logic [7:0] b;
        logic       st;
        drain();
        tx_idle_en = tx_idle;
        rx_idle_en = rx_idle;
        cfg_write(CFG_BPP, CFG_DATA_W'(bpp));
        cfg_write(CFG_ROW_BYTES, CFG_DATA_W'(rb));
        cfg_end();
        if (hold) begin
            hold_reqs++;
        end
        rb_eff = (rb == 0) ? 1 : ((rb > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF : rb);
        left   = 0;
        for (i = 0; i < n_items; i++) begin
            if (i == 0 || (noisy && $urandom_range(0, 99) < 3)) begin
                st   = 1'b1;
                b    = pick_type(noisy);
                left = rb_eff;
            end else if (left == 0) begin
                st   = noisy && ($urandom_range(0, 99) < 10);
                b    = pick_type(noisy);
                left = rb_eff;
            end else begin
                st   = 1'b0;
                b    = 8'($urandom_range(0, 255));
                left--;
            end
            send_beat(b, st);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        cfg_write(CFG_BPP, CFG_DATA_W'(1));
        cfg_write(CFG_ROW_BYTES, CFG_DATA_W'(2));
        cfg_end();
        // first row with Up, then every filter, bad types, a dropped row
        send_beat(8'(FILT_UP), 1'b1);    send_beat(8'hFF, 1'b0); send_beat(8'h01, 1'b0);
        send_beat(8'(FILT_SUB), 1'b0);   send_beat(8'h80, 1'b0); send_beat(8'h80, 1'b0);
        send_beat(8'(FILT_AVG), 1'b0);   send_beat(8'hFF, 1'b0); send_beat(8'hFF, 1'b0);
        send_beat(8'(FILT_PAETH), 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h7F, 1'b0);
        send_beat(8'd5, 1'b0);           send_beat(8'h12, 1'b0); send_beat(8'h34, 1'b0);
        send_beat(8'hFF, 1'b0);          send_beat(8'h00, 1'b0); send_beat(8'hFF, 1'b0);
        send_beat(8'(FILT_NONE), 1'b0);  send_beat(8'hAA, 1'b0);
        send_beat(8'(FILT_AVG), 1'b1);   send_beat(8'h55, 1'b0);
        // shorten the row while it is under way
        drain();
        cfg_write(CFG_ROW_BYTES, CFG_DATA_W'(1));
        cfg_end();
        send_beat(8'hC3, 1'b0);
        send_beat(8'(FILT_PAETH), 1'b0); send_beat(8'h01, 1'b0);

        run_phase(0, 0, 40, 1'b1, 1'b1, 1'b1, 1'b0);
        run_phase(15, 20, 80, 1'b1, 1'b1, 1'b1, 1'b0);
        run_phase(8, 24, 80, 1'b0, 1'b0, 1'b1, 1'b0);
        run_phase(1, 7, 60, 1'b1, 1'b1, 1'b1, 1'b0);
        run_phase(3, 9, 60, 1'b1, 1'b1, 1'b1, 1'b1);
        run_phase($urandom_range(1, 8), $urandom_range(1, 40), 80, 1'b1, 1'b1, 1'b1, 1'b0);
        run_phase(5, 16383, 40, 1'b0, 1'b0, 1'b0, 1'b0);
        run_phase($urandom_range(0, 15), $urandom_range(1, 40), 80, 1'b1, 1'b0, 1'b1, 1'b0);
        run_phase(2, $urandom_range(1, 40), 60, 1'b0, 1'b1, 1'b1, 1'b0);
        drain();

        $display("Sent %0d input beats and got %0d output beats over %0d register settings.",
                 beats_in, result_count, n_settings);
        $display("Covered all five filters, bad types, image restarts, pixel sizes 0..15 "
                 , "and row lengths 0..16383, with stalls on both sides.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
